// ===== rtl/bpx_pkg.sv =====
// ----------------------------------------------------------------------------
// bpx_pkg
// shared types and constants for the byte pair expander
// ----------------------------------------------------------------------------
package bpx_pkg;

   localparam int STACK_DEPTH_DEF = 30;
   localparam int MAX_RUN_DEF     = 64;

   localparam logic [8:0] TABLE_END = 9'h100;
   localparam logic [7:0] SKIP_BIAS = 8'h7F;

   typedef enum logic [2:0] {
      ST_COUNT,
      ST_LEFT,
      ST_RIGHT,
      ST_SIZE_HI,
      ST_SIZE_LO,
      ST_CODES,
      ST_LOOKUP,
      ST_EVAL
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_COUNT,
      OP_LEFT,
      OP_RIGHT,
      OP_SIZE_HI,
      OP_SIZE_LO,
      OP_START,
      OP_PUSH,
      OP_POP
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      emit;
      logic      last;
      logic      err;
      logic      new_block;
   } dp_cmd_type;

   typedef struct packed {
      logic skip_end;
      logic left_is_code;
      logic pair_end;
      logic pairs_more;
      logic size_zero;
      logic block_done;
      logic literal;
      logic stack_empty;
      logic overflow;
      logic run_cap;
      logic out_free;
   } dp_status_type;

endpackage

// ===== rtl/bpx_datapath.sv =====
// ----------------------------------------------------------------------------
// bpx_datapath
// pair tables, expansion stack, block counters and result register
// ----------------------------------------------------------------------------
module bpx_datapath
   import bpx_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int MAX_RUN     = MAX_RUN_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [7:0]    in_byte,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic          rsp_stall,
   output logic          rsp_valid,
   output logic [7:0]    rsp_out_byte,
   output logic          rsp_run_last,
   output logic          rsp_error_flag
);

   localparam int TOP_W = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W = $clog2(STACK_DEPTH);
   localparam int RUN_W = $clog2(MAX_RUN + 1);

   logic [7:0] left_mem  [256];
   logic [7:0] right_mem [256];
   logic [7:0] stack_mem [STACK_DEPTH];

   logic [255:0] left_valid_ff;
   logic [7:0]   left_rd_ff;
   logic [7:0]   right_rd_ff;
   logic         valid_rd_ff;
   logic [7:0]   stack_rd_ff;
   logic [IDX_W-1:0] stack_rd_addr;

   logic [8:0]       table_code_ff,    table_code_in;
   logic [6:0]       pairs_left_ff,    pairs_left_in;
   logic [7:0]       size_hi_ff,       size_hi_in;
   logic [15:0]      expected_size_ff, expected_size_in;
   logic [15:0]      codes_done_ff,    codes_done_in;
   logic [7:0]       cur_code_ff,      cur_code_in;
   logic [TOP_W-1:0] stack_top_ff,     stack_top_in;
   logic [RUN_W-1:0] run_cnt_ff,       run_cnt_in;
   logic             rsp_valid_ff,     rsp_valid_in;
   logic [7:0]       rsp_byte_ff;
   logic             rsp_last_ff;
   logic             rsp_err_ff;
   logic [9:0]       skip_sum;

   assign skip_sum = 10'(table_code_ff) + 10'(in_byte - SKIP_BIAS);
   assign stack_rd_addr = (stack_top_ff == '0) ? '0 : IDX_W'(stack_top_ff - 1'b1);

   // status
   always_comb begin
      status.skip_end     = in_byte[7] ? (skip_sum >= 10'(TABLE_END))
                                       : (table_code_ff >= TABLE_END);
      status.left_is_code = (in_byte == table_code_ff[7:0]);
      status.pair_end     = (table_code_ff[7:0] == 8'hFF);
      status.pairs_more   = (pairs_left_ff != '0);
      status.size_zero    = ({size_hi_ff, in_byte} == 16'h0000);
      status.block_done   = (codes_done_ff == expected_size_ff);
      status.literal      = valid_rd_ff ? (left_rd_ff == cur_code_ff) : 1'b1;
      status.stack_empty  = (stack_top_ff == '0);
      status.overflow     = (({1'b0, stack_top_ff} + (TOP_W+1)'(2)) >
                             (TOP_W+1)'(STACK_DEPTH));
      status.run_cap      = (run_cnt_ff == RUN_W'(MAX_RUN - 1));
      status.out_free     = !rsp_valid_ff || !rsp_stall;
   end

   // memories
   always_ff @(posedge clock) begin
      if (cmd.op == OP_LEFT) begin
         left_mem[table_code_ff[7:0]] <= in_byte;
      end
      if (cmd.op == OP_RIGHT) begin
         right_mem[table_code_ff[7:0]] <= in_byte;
      end
      if (cmd.op == OP_PUSH) begin
         stack_mem[stack_top_ff[IDX_W-1:0]] <= right_rd_ff;
      end
      left_rd_ff  <= left_mem[cur_code_ff];
      right_rd_ff <= right_mem[cur_code_ff];
      valid_rd_ff <= left_valid_ff[cur_code_ff];
      stack_rd_ff <= stack_mem[stack_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.new_block) begin
         left_valid_ff <= '0;
      end else if (cmd.op == OP_LEFT) begin
         left_valid_ff[table_code_ff[7:0]] <= 1'b1;
      end
   end

   // next values
   always_comb begin
      table_code_in    = table_code_ff;
      pairs_left_in    = pairs_left_ff;
      size_hi_in       = size_hi_ff;
      expected_size_in = expected_size_ff;
      codes_done_in    = codes_done_ff;
      cur_code_in      = cur_code_ff;
      stack_top_in     = stack_top_ff;
      run_cnt_in       = run_cnt_ff;
      case (cmd.op)
         OP_COUNT: begin
            if (in_byte[7]) begin
               table_code_in = (skip_sum >= 10'(TABLE_END)) ? TABLE_END : skip_sum[8:0];
               pairs_left_in = '0;
            end else begin
               pairs_left_in = in_byte[6:0];
            end
         end
         OP_LEFT, OP_RIGHT: begin
            if (cmd.op == OP_RIGHT || status.left_is_code) begin
               table_code_in = 9'(table_code_ff + 9'd1);
               if (!status.pair_end && status.pairs_more) begin
                  pairs_left_in = 7'(pairs_left_ff - 7'd1);
               end
            end
         end
         OP_SIZE_HI: size_hi_in = in_byte;
         OP_SIZE_LO: begin
            expected_size_in = {size_hi_ff, in_byte};
            codes_done_in    = '0;
         end
         OP_START: begin
            cur_code_in   = in_byte;
            stack_top_in  = '0;
            run_cnt_in    = '0;
            codes_done_in = 16'(codes_done_ff + 16'd1);
         end
         OP_PUSH: begin
            stack_top_in = TOP_W'(stack_top_ff + 1'b1);
            cur_code_in  = left_rd_ff;
         end
         OP_POP: begin
            stack_top_in = TOP_W'(stack_top_ff - 1'b1);
            cur_code_in  = stack_rd_ff;
         end
         default: ;
      endcase
      if (cmd.emit) begin
         run_cnt_in = RUN_W'(run_cnt_ff + 1'b1);
      end
      if (cmd.new_block) begin
         table_code_in = '0;
         pairs_left_in = '0;
         codes_done_in = '0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_code_ff    <= '0;
         pairs_left_ff    <= '0;
         size_hi_ff       <= '0;
         expected_size_ff <= '0;
         codes_done_ff    <= '0;
         stack_top_ff     <= '0;
         run_cnt_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         table_code_ff    <= table_code_in;
         pairs_left_ff    <= pairs_left_in;
         size_hi_ff       <= size_hi_in;
         expected_size_ff <= expected_size_in;
         codes_done_ff    <= codes_done_in;
         stack_top_ff     <= stack_top_in;
         run_cnt_ff       <= run_cnt_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_code_ff <= cur_code_in;
      if (cmd.emit) begin
         rsp_byte_ff <= cur_code_ff;
         rsp_last_ff <= cmd.last;
         rsp_err_ff  <= cmd.err;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_run_last   = rsp_last_ff;
   assign rsp_error_flag = rsp_err_ff;

endmodule

// ===== rtl/bpx_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpx_ctrl
// stream phase and expansion sequencer
// ----------------------------------------------------------------------------
module bpx_ctrl
   import bpx_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      accepting;
   logic      accept;

   assign accepting = state_ff inside {ST_COUNT, ST_LEFT, ST_RIGHT,
                                       ST_SIZE_HI, ST_SIZE_LO, ST_CODES};
   assign req_stall = !accepting;
   assign accept    = req_valid && accepting;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_COUNT: begin
            if (accept) begin
               state_in = status.skip_end ? ST_SIZE_HI : ST_LEFT;
            end
         end
         ST_LEFT, ST_RIGHT: begin
            if (accept) begin
               if (state_ff == ST_LEFT && !status.left_is_code) begin
                  state_in = ST_RIGHT;
               end else if (status.pair_end) begin
                  state_in = ST_SIZE_HI;
               end else if (status.pairs_more) begin
                  state_in = ST_LEFT;
               end else begin
                  state_in = ST_COUNT;
               end
            end
         end
         ST_SIZE_HI: begin
            if (accept) begin
               state_in = ST_SIZE_LO;
            end
         end
         ST_SIZE_LO: begin
            if (accept) begin
               state_in = status.size_zero ? ST_COUNT : ST_CODES;
            end
         end
         ST_CODES: begin
            if (accept) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: state_in = ST_EVAL;
         ST_EVAL: begin
            if (!status.literal && !status.overflow) begin
               state_in = ST_LOOKUP;
            end else if (status.out_free) begin
               if (status.literal && !status.stack_empty && !status.run_cap) begin
                  state_in = ST_LOOKUP;
               end else begin
                  state_in = status.block_done ? ST_COUNT : ST_CODES;
               end
            end
         end
         default: state_in = ST_COUNT;
      endcase
   end

   // commands
   always_comb begin
      cmd = '{op: OP_NONE, emit: 1'b0, last: 1'b0, err: 1'b0, new_block: 1'b0};
      case (state_ff)
         ST_COUNT:   if (accept) cmd.op = OP_COUNT;
         ST_LEFT:    if (accept) cmd.op = OP_LEFT;
         ST_RIGHT:   if (accept) cmd.op = OP_RIGHT;
         ST_SIZE_HI: if (accept) cmd.op = OP_SIZE_HI;
         ST_SIZE_LO: begin
            if (accept) begin
               cmd.op        = OP_SIZE_LO;
               cmd.new_block = status.size_zero;
            end
         end
         ST_CODES:   if (accept) cmd.op = OP_START;
         ST_EVAL: begin
            if (!status.literal && !status.overflow) begin
               cmd.op = OP_PUSH;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.literal && !status.stack_empty && !status.run_cap) begin
                  cmd.op = OP_POP;
               end else begin
                  cmd.last      = 1'b1;
                  cmd.err       = !status.literal || !status.stack_empty;
                  cmd.new_block = status.block_done;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COUNT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/byte_pair_expander.sv =====
// ----------------------------------------------------------------------------
// byte_pair_expander
// byte pair encoding decompressor with capped runs
// ----------------------------------------------------------------------------
// A code byte enters and then runs through expansion steps (one per literal
// byte and one per pair pushed), each a lookup state and an evaluate state,
// set by the registered read of the pair tables and the stack that every
// step waits on; no new byte is taken until the run is done, and a stalled
// result port holds the next literal. The left table comes back to identity
// once a block ends, through one valid bit per code.
module byte_pair_expander
   import bpx_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int MAX_RUN     = MAX_RUN_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_error_flag
);

   dp_cmd_type    cmd;
   dp_status_type status;

   bpx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bpx_datapath #(
      .STACK_DEPTH (STACK_DEPTH),
      .MAX_RUN     (MAX_RUN)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .in_byte        (req_in_byte),
      .cmd            (cmd),
      .status         (status),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_error_flag (rsp_error_flag)
   );

endmodule

// ===== bench/byte_pair_expander_tb.sv =====
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the byte pair expander. Compressed streams of
// pair tables, sizes and codes are sent with random gaps on both sides.
// Each item goes through a predictor of the pair tables and the expansion
// stack, and every expanded byte is checked field by field in order.
// ----------------------------------------------------------------------------
module testbench;
   import bpx_pkg::*;

   localparam int CLOCK_HALF   = 10;
   localparam int RESET_CYCLES = 12;
   localparam int DRAIN_CYCLES = 400;
   localparam int LIMIT_CYCLES = 1000000;
   localparam int RANDOM_ITEMS = 130;
   localparam logic [7:0] COUNT_SKIP = 8'h80;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       err;
   } expanded_byte_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_last;
   logic       rsp_error_flag;

   logic [7:0] left_map [256];
   logic [7:0] right_map [256];
   logic [7:0] unwind [STACK_DEPTH_DEF];
   state_type  pred_phase;
   logic [8:0] next_code;
   logic [7:0] pairs_rem;
   logic [15:0] block_size;
   logic [15:0] codes_seen;
   expanded_byte_type expected_bytes [$];

   int errors     = 0;
   int sent_items = 0;
   bit idle_on    = 1'b1;

   byte_pair_expander dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_error_flag (rsp_error_flag)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
   endtask

   task automatic start_block();
      for (int i = 0; i < 256; i++) left_map[i] = i[7:0];
      next_code  = '0;
      pairs_rem  = '0;
      codes_seen = '0;
      pred_phase = ST_COUNT;
   endtask

   task automatic reset_predictor();
      for (int i = 0; i < 256; i++) right_map[i] = 8'h00;
      block_size = '0;
      start_block();
   endtask

   task automatic close_pair();
      next_code = next_code + 9'd1;
      if (next_code >= TABLE_END) begin
         next_code  = TABLE_END;
         pred_phase = ST_SIZE_HI;
      end else if (pairs_rem != 0) begin
         pairs_rem  = pairs_rem - 8'd1;
         pred_phase = ST_LEFT;
      end else begin
         pred_phase = ST_COUNT;
      end
   endtask

   task automatic expand_code(input logic [7:0] code);
      logic [7:0] c;
      int         n;
      int         top;
      bit         done;
      c    = code;
      n    = 0;
      top  = 0;
      done = 1'b0;
      while (!done) begin
         if (left_map[c] == c) begin
            n++;
            if (top == 0) begin
               expected_bytes.push_back({c, 1'b1, 1'b0});
               done = 1'b1;
            end else if (n >= MAX_RUN_DEF) begin
               expected_bytes.push_back({c, 1'b1, 1'b1});
               done = 1'b1;
            end else begin
               expected_bytes.push_back({c, 1'b0, 1'b0});
               top--;
               c = unwind[top];
            end
         end else if (top + 2 > STACK_DEPTH_DEF) begin
            // no room for both halves of the pair
            expected_bytes.push_back({c, 1'b1, 1'b1});
            done = 1'b1;
         end else begin
            unwind[top] = right_map[c];
            top++;
            c = left_map[c];
         end
      end
   endtask

   task automatic predict_byte(input logic [7:0] b);
      int nc;
      case (pred_phase)
         ST_COUNT: begin
            if (b >= COUNT_SKIP) begin
               nc        = next_code + (b - SKIP_BIAS);
               pairs_rem = '0;
            end else begin
               nc        = next_code;
               pairs_rem = b;
            end
            if (nc >= TABLE_END) begin
               next_code  = TABLE_END;
               pred_phase = ST_SIZE_HI;
            end else begin
               next_code  = nc[8:0];
               pred_phase = ST_LEFT;
            end
         end
         ST_LEFT: begin
            left_map[next_code[7:0]] = b;
            if (b != next_code[7:0]) pred_phase = ST_RIGHT;
            else close_pair();
         end
         ST_RIGHT: begin
            right_map[next_code[7:0]] = b;
            close_pair();
         end
         ST_SIZE_HI: begin
            block_size = {b, 8'h00};
            pred_phase = ST_SIZE_LO;
         end
         ST_SIZE_LO: begin
            block_size[7:0] = b;
            codes_seen      = '0;
            if (block_size == 0) start_block();
            else pred_phase = ST_CODES;
         end
         default: begin
            expand_code(b);
            codes_seen = codes_seen + 16'd1;
            if (codes_seen == block_size) start_block();
         end
      endcase
   endtask

   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (sent_items % 24 == 0) idle_on = ($urandom_range(0, 3) != 0);
      gap = idle_on ? $urandom_range(0, 3) : 0;
      predict_byte(b);
      sent_items++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   function automatic logic [7:0] near_code();
      return next_code[7:0] - 8'($urandom_range(1, 6));
   endfunction

   // next stream byte, shaped by what the stream expects next
   function automatic logic [7:0] pick_byte(input bit noisy);
      int         r;
      logic [7:0] c;
      r = $urandom_range(0, 19);
      if (pred_phase == ST_SIZE_HI) return 8'h00;
      if (pred_phase == ST_SIZE_LO) begin
         if (r < 2) return 8'h00;
         return 8'($urandom_range(1, noisy ? 4 : 12));
      end
      if (noisy) return 8'($urandom_range(0, 255));
      case (pred_phase)
         ST_COUNT: begin
            if (r < 12) return COUNT_SKIP | 8'($urandom_range(24, 127));
            if (r < 19) return 8'($urandom_range(0, 7));
            return 8'($urandom_range(0, 127));
         end
         ST_LEFT: begin
            if (r < 3) return next_code[7:0];
            if (r < 13) return near_code();
            return 8'($urandom_range(0, 255));
         end
         ST_RIGHT: begin
            if (r < 10) return near_code();
            return 8'($urandom_range(0, 255));
         end
         default: begin
            c = 8'($urandom_range(0, 255));
            if (r < 14) begin
               repeat (8) if (left_map[c] == c) c = 8'($urandom_range(0, 255));
            end
            return c;
         end
      endcase
   endfunction

   task automatic finish_block();
      while (!(pred_phase == ST_COUNT && next_code == 0)) send_byte(pick_byte(1'b0));
   endtask

   // literal pair, capped run, stack overflow, table filling during pairs
   task automatic test_pair_table_special_cases();
      logic [7:0] stream_a [19] = '{
         8'h01, 8'h00, 8'h41, 8'h42,
         8'hFC, 8'h43, 8'h7F,
         8'hFD, 8'hFF, 8'h30,
         8'h05, 8'hFE, 8'h31,
         8'h00, 8'h04,
         8'h01, 8'h7F, 8'hFE, 8'h80
      };
      foreach (stream_a[i]) send_byte(stream_a[i]);
   endtask

   // skip past the table end, then an empty block
   task automatic test_table_skip_and_empty_block();
      logic [7:0] stream_b [5] = '{8'hFF, 8'h80, 8'hFF, 8'h00, 8'h00};
      foreach (stream_b[i]) send_byte(stream_b[i]);
   endtask

   task automatic test_random_blocks();
      int target;
      target = sent_items + RANDOM_ITEMS;
      while (sent_items < target) send_byte(pick_byte(1'b0));
      finish_block();
   endtask

   task automatic test_stream_noise();
      repeat ($urandom_range(6, 14)) send_byte(pick_byte(1'b1));
      finish_block();
   endtask

   initial begin : result_stall
      int w;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            w = idle_on ? $urandom_range(0, 3) : 0;
            if (w > 0) begin
               rsp_stall <= 1'b1;
               repeat (w) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_results
      expanded_byte_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected item, byte %02h", rsp_out_byte));
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_out_byte !== want.data)
               report_mismatch($sformatf("out_byte %02h, want %02h", rsp_out_byte, want.data));
            if (rsp_run_last !== want.last)
               report_mismatch($sformatf("run_last %0b, want %0b", rsp_run_last, want.last));
            if (rsp_error_flag !== want.err)
               report_mismatch($sformatf("error_flag %0b, want %0b",
                                         rsp_error_flag, want.err));
         end
      end
   end

   initial begin
      reset_predictor();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_pair_table_special_cases();
      test_table_skip_and_empty_block();
      test_random_blocks();
      test_stream_noise();
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #(LIMIT_CYCLES * 2 * CLOCK_HALF);
      $display("Verification failed");
      $finish;
   end

endmodule
